[hdl/cpu_mailbox_irq_status_assert.svh]
// Assertion macros shared by the mailbox RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef CPU_MAILBOX_IRQ_STATUS_ASSERT_SVH
`define CPU_MAILBOX_IRQ_STATUS_ASSERT_SVH

// Same-cycle implication.
`define CMIS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmis assertion failed");

// Next-cycle implication.
`define CMIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmis assertion failed");

`endif

[hdl/cmis_pkg.sv]
// Package for the CPU mailbox / IRQ status block: request codes, bus map,
// buffer sizing and the reply buffer command struct. No dependencies.
`default_nettype none

package cmis_pkg;

   localparam int unsigned REPLY_DEPTH_DEF = 64;

   typedef enum logic [2:0] {
      REQ_MAIN_READ  = 3'd0,
      REQ_MAIN_WRITE = 3'd1,
      REQ_PORT_READ  = 3'd2,
      REQ_PORT_WRITE = 3'd3,
      REQ_VBLANK     = 3'd4
   } req_code_type;

   localparam logic [23:0] ADDR_STATUS_A  = 24'h300000;
   localparam logic [23:0] ADDR_STATUS_B  = 24'h300002;
   localparam logic [23:0] ADDR_ACK_VIDEO = 24'h300004;
   localparam logic [23:0] ADDR_ACK_OTHER = 24'h300006;
   localparam logic [23:0] ADDR_LATCH     = 24'h30006E;
   localparam logic [7:0]  PORT_LATCH     = 8'h30;
   localparam logic [7:0]  PORT_REPLY     = 8'h10;

   typedef struct packed {
      logic       pop;
      logic       push;
      logic [7:0] data;
   } reply_cmd_type;

endpackage

`default_nettype wire

[hdl/cmis_req_if.sv]
// Request channel interface: valid/ready plus the request payload.
// Depends on nothing.
`default_nettype none

interface cmis_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [23:0] address;
   logic [15:0] write_data;

   modport source (output valid, output req_type, output address, output write_data,
                   input ready);
   modport sink   (input valid, input req_type, input address, input write_data,
                   output ready);
endinterface

`default_nettype wire

[hdl/cmis_rsp_if.sv]
// Response channel interface: valid/ready plus the response payload.
// Depends on nothing.
`default_nettype none

interface cmis_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic        main_irq;
   logic        sound_nmi;

   modport source (output valid, output read_data, output main_irq, output sound_nmi,
                   input ready);
   modport sink   (input valid, input read_data, input main_irq, input sound_nmi,
                   output ready);
endinterface

`default_nettype wire

[hdl/cmis_reply_buf.sv]
// Reply byte buffer: sound CPU pushes, main CPU pops in order.
// Depends on cmis_pkg and cpu_mailbox_irq_status_assert.svh.
`default_nettype none
`include "cpu_mailbox_irq_status_assert.svh"

module cmis_reply_buf #(
   parameter int unsigned REPLY_DEPTH = cmis_pkg::REPLY_DEPTH_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  cmis_pkg::reply_cmd_type cmd,
   output logic [7:0]              pop_data
);

   localparam int unsigned CNT_W = $clog2(REPLY_DEPTH + 1);
   localparam int unsigned IDX_W = (REPLY_DEPTH > 1) ? $clog2(REPLY_DEPTH) : 1;

   logic [7:0]       reply_mem [REPLY_DEPTH];
   logic [CNT_W-1:0] read_pos_ff, read_pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] count_eff;
   logic [7:0]       q_ff;
   logic             empty;
   logic             full;
   logic             do_write;

   always_comb begin
      empty     = read_pos_ff >= count_ff;
      // a push after the buffer drained restarts from entry zero
      count_eff = empty ? '0 : count_ff;
      full      = count_eff == CNT_W'(REPLY_DEPTH);
      do_write  = cmd.push && !full;
      read_pos_in = read_pos_ff;
      count_in    = count_ff;
      if (cmd.pop) begin
         if (empty) begin
            read_pos_in = '0;
            count_in    = '0;
         end else begin
            read_pos_in = read_pos_ff + CNT_W'(1);
         end
      end else if (cmd.push) begin
         if (empty) begin
            read_pos_in = '0;
         end
         count_in = full ? count_eff : count_eff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_pos_ff <= '0;
         count_ff    <= '0;
      end else begin
         read_pos_ff <= read_pos_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         reply_mem[count_eff[IDX_W-1:0]] <= cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         q_ff <= empty ? 8'h00 : reply_mem[read_pos_ff[IDX_W-1:0]];
      end
   end

   assign pop_data = q_ff;

   `CMIS_ASSERT_NOW(count_in_range, clock, reset, 1'b1, count_ff <= CNT_W'(REPLY_DEPTH))
   `CMIS_ASSERT_NOW(pos_le_count, clock, reset, 1'b1, read_pos_ff <= count_ff)
   `CMIS_ASSERT_NEXT(push_grows, clock, reset, cmd.push && !cmd.pop && !empty && !full,
                     count_ff == $past(count_ff) + CNT_W'(1))

endmodule

`default_nettype wire

[hdl/cpu_mailbox_irq_status.sv]
// A request transaction passes the input register, then the result register, before its
// response transaction; response valid rises when the result register loads.
// Throughput: one transaction per cycle unless the response side stalls; a pop reads the
// reply buffer at acceptance and its registered byte joins the result in the result
// register. A full response register back-pressures through the input register.
// Reset (synchronous, active high): flags not pending, latch 0, buffer empty,
// both pipeline registers empty. The reply buffer memory is not cleared.
`default_nettype none
`include "cpu_mailbox_irq_status_assert.svh"

module cpu_mailbox_irq_status #(
   parameter int unsigned REPLY_DEPTH = cmis_pkg::REPLY_DEPTH_DEF
) (
   input wire         clock,
   input wire         reset,
   cmis_req_if.sink   req_bus,
   cmis_rsp_if.source rsp_bus
);

   logic        accept;
   logic        a_move;
   logic        is_main_rd;
   logic        is_main_wr;
   logic        is_port_rd;
   logic        is_port_wr;
   logic        is_vblank;
   logic [15:0] status;
   logic [15:0] rd_in;
   logic        pop_in;
   logic        nmi_in;

   logic        video_n_ff, video_n_in;
   logic        other_n_ff, other_n_in;
   logic [15:0] latch_ff, latch_in;

   logic        a_valid_ff, a_valid_in;
   logic [15:0] a_rd_ff;
   logic        a_pop_ff;
   logic        a_irq_ff;
   logic        a_nmi_ff;

   logic        b_valid_ff, b_valid_in;
   logic [15:0] b_rd_ff;
   logic        b_irq_ff;
   logic        b_nmi_ff;

   logic [7:0]              pop_data;
   cmis_pkg::reply_cmd_type buf_cmd;

   assign a_move        = a_valid_ff && (!b_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !a_valid_ff || a_move;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      is_main_rd = accept && (req_bus.req_type == cmis_pkg::REQ_MAIN_READ);
      is_main_wr = accept && (req_bus.req_type == cmis_pkg::REQ_MAIN_WRITE);
      is_port_rd = accept && (req_bus.req_type == cmis_pkg::REQ_PORT_READ);
      is_port_wr = accept && (req_bus.req_type == cmis_pkg::REQ_PORT_WRITE);
      is_vblank  = accept && (req_bus.req_type == cmis_pkg::REQ_VBLANK);
      status     = {14'd0, other_n_ff, video_n_ff};

      rd_in      = 16'd0;
      pop_in     = 1'b0;
      nmi_in     = 1'b0;
      video_n_in = video_n_ff;
      other_n_in = other_n_ff;
      latch_in   = latch_ff;

      if (is_main_rd) begin
         priority if (req_bus.address == cmis_pkg::ADDR_STATUS_A ||
                      req_bus.address == cmis_pkg::ADDR_STATUS_B) begin
            rd_in = status;
         end else if (req_bus.address == cmis_pkg::ADDR_ACK_VIDEO) begin
            rd_in      = status;
            video_n_in = 1'b1;
         end else if (req_bus.address == cmis_pkg::ADDR_ACK_OTHER) begin
            rd_in      = status;
            other_n_in = 1'b1;
         end else if (req_bus.address == cmis_pkg::ADDR_LATCH) begin
            pop_in = 1'b1;
         end else begin
            rd_in = 16'd0;
         end
      end
      if (is_main_wr && req_bus.address == cmis_pkg::ADDR_LATCH) begin
         latch_in = req_bus.write_data;
         nmi_in   = 1'b1;
      end
      if (is_port_rd && req_bus.address[7:0] == cmis_pkg::PORT_LATCH) begin
         rd_in = {8'd0, latch_ff[7:0]};
      end
      if (is_vblank) begin
         video_n_in = 1'b0;
         other_n_in = 1'b0;
      end

      buf_cmd.pop  = pop_in;
      buf_cmd.push = is_port_wr && (req_bus.address[7:0] == cmis_pkg::PORT_REPLY);
      buf_cmd.data = req_bus.write_data[7:0];

      a_valid_in = accept || (a_valid_ff && !a_move);
      b_valid_in = a_move || (b_valid_ff && !rsp_bus.ready);
   end

   cmis_reply_buf #(
      .REPLY_DEPTH(REPLY_DEPTH)
   ) u_reply_buf (
      .clock   (clock),
      .reset   (reset),
      .cmd     (buf_cmd),
      .pop_data(pop_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         video_n_ff <= 1'b1;
         other_n_ff <= 1'b1;
         latch_ff   <= 16'd0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         video_n_ff <= video_n_in;
         other_n_ff <= other_n_in;
         latch_ff   <= latch_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // input-side result register, pop byte arrives from the buffer's read register
   always_ff @(posedge clock) begin
      if (accept) begin
         a_rd_ff  <= rd_in;
         a_pop_ff <= pop_in;
         a_irq_ff <= !(video_n_in && other_n_in);
         a_nmi_ff <= nmi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_rd_ff  <= a_pop_ff ? {8'd0, pop_data} : a_rd_ff;
         b_irq_ff <= a_irq_ff;
         b_nmi_ff <= a_nmi_ff;
      end
   end

   assign rsp_bus.valid     = b_valid_ff;
   assign rsp_bus.read_data = b_rd_ff;
   assign rsp_bus.main_irq  = b_irq_ff;
   assign rsp_bus.sound_nmi = b_nmi_ff;

   `CMIS_ASSERT_NEXT(vblank_raises, clock, reset, is_vblank, !video_n_ff && !other_n_ff)
   `CMIS_ASSERT_NOW(nmi_no_data, clock, reset, rsp_bus.valid && rsp_bus.sound_nmi,
                    rsp_bus.read_data == 16'd0)
   `CMIS_ASSERT_NOW(stall_only_full, clock, reset, !req_bus.ready,
                    a_valid_ff && b_valid_ff)
   `CMIS_ASSERT_NOW(nmi_irq_consistent, clock, reset, a_valid_ff && a_nmi_ff,
                    !a_pop_ff && a_rd_ff == 16'd0)

endmodule

`default_nettype wire
